// ===== src/tlv_element_inserter_defines.svh =====
// assertion macros for the tlv element inserter checker
`ifndef TLV_ELEMENT_INSERTER_DEFINES_SVH
`define TLV_ELEMENT_INSERTER_DEFINES_SVH

// property checked on every clock edge outside reset
`define TLV_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tlv element inserter assertion failed");

// property checked on every clock edge, reset included
`define TLV_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tlv element inserter assertion failed");

`endif

// ===== src/tlv_pkg.sv =====
// shared types, constants and register codes of the tlv element inserter
`default_nettype none
package tlv_pkg;

    localparam int DEF_MAX_REGION_BYTES = 4095;
    localparam int MAX_RESULTS = 7;
    localparam int CNT_W = 3;

    // configuration register indexes
    localparam logic [1:0] CFG_INSERT_TAG    = 2'd0;
    localparam logic [1:0] CFG_INSERT_LENGTH = 2'd1;
    localparam logic [1:0] CFG_INSERT_VALUE  = 2'd2;

    // configuration reset values
    localparam logic [7:0]  RST_INSERT_TAG    = 8'h25;
    localparam logic [2:0]  RST_INSERT_LENGTH = 3'h3;
    localparam logic [31:0] RST_INSERT_VALUE  = 32'h0001_0B03;

    localparam logic [2:0] MAX_VALUE_BYTES = 3'd4;

    typedef enum logic [1:0] {
        PH_TAG,
        PH_LEN,
        PH_VAL,
        PH_DROP
    } t_phase;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        has_byte;
        logic [11:0] region_length;
        logic        region_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       out_last;
    } t_out_item;

    typedef struct packed {
        logic [CNT_W-1:0]                count;
        t_out_item [MAX_RESULTS-1:0]     items;
    } t_batch;

    typedef struct packed {
        logic [7:0]  insert_tag;
        logic [2:0]  insert_length;
        logic [31:0] insert_value;
    } t_cfg;

endpackage
`default_nettype wire

// ===== src/tlv_parse.sv =====
// element parser: region state and the batch of result items for one item
`default_nettype none
module tlv_parse
    import tlv_pkg::*;
#(
    parameter int MAX_REGION_BYTES = DEF_MAX_REGION_BYTES
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_batch        o_batch
);

    localparam int OW = $clog2(MAX_REGION_BYTES + 1);
    localparam int CW = ((OW > 12) ? OW : 12) + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_REGION_BYTES);
    localparam logic [OW-1:0] MAX_O = OW'(MAX_REGION_BYTES);

    logic [OW-1:0] r_offset,  n_offset;
    t_phase        r_phase,   n_phase;
    logic [7:0]    r_remain,  n_remain;
    logic          r_ins,     n_ins;
    logic          r_seen,    n_seen;

    logic [CW-1:0] rlen;
    logic [CW-1:0] off_c;
    logic [CW-1:0] byte_c;
    logic          emit;
    logic          pre;
    logic          post;
    logic [2:0]    len_eff;
    logic [2:0]    elen;
    logic [2:0]    start_b;
    logic [2:0]    start_p;
    logic [2:0]    cnt;
    logic [2:0]    kk;
    logic [2:0]    rel;

    // byte idx of the configured element: tag, length, value bytes
    function automatic logic [7:0] elem_byte(input logic [2:0] idx, input t_cfg cfg,
                                             input logic [2:0] len);
        logic [2:0] vi;
        logic [1:0] sh;
        vi = idx - 3'd2;
        sh = 2'(len - 3'd1 - vi);
        case (idx)
            3'd0:    elem_byte = cfg.insert_tag;
            3'd1:    elem_byte = {5'd0, len};
            default: elem_byte = cfg.insert_value[{sh, 3'b000} +: 8];
        endcase
    endfunction

    always_comb begin
        len_eff = (i_cfg.insert_length > MAX_VALUE_BYTES) ? MAX_VALUE_BYTES
                                                           : i_cfg.insert_length;
        elen    = 3'd2 + len_eff;

        rlen = (CW'(i_item.region_length) > MAX_C) ? MAX_C : CW'(i_item.region_length);
        off_c  = CW'(r_offset);
        byte_c = CW'(i_item.data_byte);

        n_offset = r_offset;
        n_phase  = r_phase;
        n_remain = r_remain;
        n_ins    = r_ins;
        n_seen   = r_seen;
        emit     = 1'b0;
        pre      = 1'b0;
        post     = 1'b0;

        if (i_item.has_byte) begin
            if (off_c < rlen) begin
                case (r_phase)
                    PH_TAG: begin
                        // a tag needs room for its length byte too
                        if (off_c + CW'(2) <= rlen) begin
                            if (i_item.data_byte == i_cfg.insert_tag) begin
                                n_seen = 1'b1;
                            end
                            if (!r_ins && !r_seen && i_item.data_byte > i_cfg.insert_tag) begin
                                pre   = 1'b1;
                                n_ins = 1'b1;
                            end
                            emit    = 1'b1;
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        emit = 1'b1;
                        if (off_c + CW'(1) + byte_c > rlen) begin
                            n_phase = PH_DROP;
                        end else if (i_item.data_byte == 8'd0) begin
                            n_phase = PH_TAG;
                        end else begin
                            n_remain = i_item.data_byte;
                            n_phase  = PH_VAL;
                        end
                    end
                    PH_VAL: begin
                        emit = 1'b1;
                        n_remain = (r_remain != 8'd0) ? r_remain - 8'd1 : r_remain;
                        if (n_remain == 8'd0) begin
                            n_phase = PH_TAG;
                        end
                    end
                    default: begin
                        // rest of the region dropped
                    end
                endcase
            end
            if (r_offset < MAX_O) begin
                n_offset = r_offset + OW'(1);
            end
        end

        if (i_item.region_end) begin
            post     = !n_ins && !n_seen;
            n_offset = '0;
            n_phase  = PH_TAG;
            n_remain = '0;
            n_ins    = 1'b0;
            n_seen   = 1'b0;
        end

        start_b = pre ? elen : 3'd0;
        start_p = start_b + {2'd0, emit};
        cnt     = start_p + (post ? elen : 3'd0);

        o_batch = '0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            kk  = 3'(k);
            rel = kk - start_p;
            if (pre && kk < elen) begin
                o_batch.items[k].out_byte  = elem_byte(kk, i_cfg, len_eff);
                o_batch.items[k].out_valid = 1'b1;
            end else if (emit && kk == start_b) begin
                o_batch.items[k].out_byte  = i_item.data_byte;
                o_batch.items[k].out_valid = 1'b1;
            end else if (post && kk >= start_p && rel < elen) begin
                o_batch.items[k].out_byte  = elem_byte(rel, i_cfg, len_eff);
                o_batch.items[k].out_valid = 1'b1;
            end
        end

        // an end item with nothing else to say gives a bare end marker
        if (i_item.region_end && cnt == 3'd0) begin
            cnt = 3'd1;
        end
        if (i_item.region_end) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                if (3'(k) == cnt - 3'd1) begin
                    o_batch.items[k].out_last = 1'b1;
                end
            end
        end
        o_batch.count = CNT_W'(cnt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_phase  <= PH_TAG;
            r_remain <= '0;
            r_ins    <= 1'b0;
            r_seen   <= 1'b0;
        end else if (i_step) begin
            r_offset <= n_offset;
            r_phase  <= n_phase;
            r_remain <= n_remain;
            r_ins    <= n_ins;
            r_seen   <= n_seen;
        end
    end

endmodule
`default_nettype wire

// ===== src/tlv_out_queue.sv =====
// result queue: holds one batch and shifts it out one item per cycle while the receiver is ready
`default_nettype none
module tlv_out_queue
    import tlv_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_load,
    input  wire t_batch    i_batch,
    output logic           o_free,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_item
);

    t_out_item [MAX_RESULTS-1:0] r_q;
    logic [CNT_W-1:0]            r_cnt;
    logic                        pop;

    assign o_out_valid = (r_cnt != '0);
    assign o_out_item  = r_q[0];
    assign pop         = o_out_valid && i_out_ready;
    // empty by the next edge
    assign o_free      = (r_cnt == '0) || (r_cnt == CNT_W'(1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_batch.count;
        end else if (pop) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_q <= i_batch.items;
        end else if (pop) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_q[k] <= r_q[k+1];
            end
            r_q[MAX_RESULTS-1] <= '0;
        end
    end

endmodule
`default_nettype wire

// ===== src/tlv_element_inserter.sv =====
// top level of the tlv element inserter
//
// rewrites the tag-length-value element region of a frame, one byte item at a time, placing
// one configured element, unless its tag was seen, before the first larger tag or at the end
// input channel: i_in_valid / o_in_ready with a t_in_item payload
// output channel: o_out_valid / i_out_ready with a t_out_item payload
// configuration: i_cfg_we writes i_cfg_index (tag, length, value) from i_cfg_wdata; the user
//   must write only while the block is idle, which the block itself does not enforce
// path: an item is taken into the input register, parsed from there and its batch loaded
//   into the result queue, from which its results appear
// throughput: one item per cycle while each item gives at most one result and the receiver
//   is ready; an item that brings the configured element with it gives up to seven result
//   items and holds the input while the result queue drains them, one per cycle while ready
// stall: when the receiver holds i_out_ready low the queue keeps its head, the parser
//   waits and the input register holds one more item before o_in_ready drops
// reset: synchronous, active low; clears the parse state, empties both stages and
//   loads the configuration reset values
`default_nettype none
module tlv_element_inserter
    import tlv_pkg::*;
#(
    parameter int MAX_REGION_BYTES = DEF_MAX_REGION_BYTES
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input item channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    // result item channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    // configuration write port
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_wdata
);

    t_cfg     r_cfg;
    logic     r_in_valid;
    t_in_item r_in;
    logic     advance;
    logic     q_free;
    t_batch   batch;

    // configuration registers, writes beyond the list are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.insert_tag    <= RST_INSERT_TAG;
            r_cfg.insert_length <= RST_INSERT_LENGTH;
            r_cfg.insert_value  <= RST_INSERT_VALUE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_INSERT_TAG:    r_cfg.insert_tag    <= i_cfg_wdata[7:0];
                CFG_INSERT_LENGTH: r_cfg.insert_length <= i_cfg_wdata[2:0];
                CFG_INSERT_VALUE:  r_cfg.insert_value  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // item moves on to the parser once the result queue has room for its batch
    assign advance    = r_in_valid && q_free;
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_item;
        end
    end

    // parse state and batch of results for the registered item
    tlv_parse #(
        .MAX_REGION_BYTES(MAX_REGION_BYTES)
    ) u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_batch (batch)
    );

    // result register, drained one item per cycle while the receiver is ready
    tlv_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (advance),
        .i_batch     (batch),
        .o_free      (q_free),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule
`default_nettype wire

// ===== src/tlv_checker.sv =====
// port checker for the tlv element inserter and its bind
`default_nettype none
`include "tlv_element_inserter_defines.svh"
module tlv_checker
    import tlv_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_item
);

    `TLV_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid)
    `TLV_ASSERT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> $stable(o_out_item))
    `TLV_ASSERT(a_marker_last, i_clk, i_rst_n, o_out_valid && !o_out_item.out_valid |-> o_out_item.out_last && o_out_item.out_byte == 8'd0)
    `TLV_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_out_valid && o_in_ready)
    `TLV_ASSERT(a_ready_when_drained, i_clk, i_rst_n, !o_out_valid && !i_in_valid && o_in_ready |=> o_in_ready)

endmodule

bind tlv_element_inserter tlv_checker u_tlv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
`default_nettype wire

// ===== sim/tb.sv =====
// self-checking testbench for the tlv element inserter: predicted rewrite against the block
`timescale 1ns / 100ps
module tb;
    import tlv_pkg::*;

    // generous ceiling: every item at seven results, each result behind a long stall
    localparam int CYCLE_LIMIT = 400000;

    // predicted rewrite of the element region, one expected result item per queue entry
    class region_rewriter;
        logic [7:0]  ins_tag;
        logic [2:0]  ins_len;
        logic [31:0] ins_val;
        logic [11:0] offset;
        t_phase      phase;
        logic [7:0]  cur_tag;
        logic [7:0]  val_left;
        bit          inserted;
        bit          seen;
        t_out_item   rewritten_q[$];
        int unsigned n_regions;
        int unsigned n_checked;
        int unsigned n_mismatch;

        function new();
            ins_tag = RST_INSERT_TAG;
            ins_len = RST_INSERT_LENGTH;
            ins_val = RST_INSERT_VALUE;
            n_regions = 0;
            n_checked = 0;
            n_mismatch = 0;
            clear_state();
        endfunction

        function void clear_state();
            offset = '0;
            phase = PH_TAG;
            cur_tag = '0;
            val_left = '0;
            inserted = 1'b0;
            seen = 1'b0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] d);
            case (idx)
                CFG_INSERT_TAG: ins_tag = d[7:0];
                CFG_INSERT_LENGTH: ins_len = d[2:0];
                CFG_INSERT_VALUE: ins_val = d;
                default: ;
            endcase
        endfunction

        function void emit(logic [7:0] b, logic v);
            t_out_item r;
            r.out_byte = b;
            r.out_valid = v;
            r.out_last = 1'b0;
            rewritten_q = {rewritten_q, r};
        endfunction

        // configured element: tag, clipped length, value bytes high first
        function void emit_element();
            int len;
            len = (ins_len > MAX_VALUE_BYTES) ? int'(MAX_VALUE_BYTES) : int'(ins_len);
            emit(ins_tag, 1'b1);
            emit(8'(len), 1'b1);
            for (int i = 0; i < len; i++)
                emit(8'(ins_val >> (8 * (len - 1 - i))), 1'b1);
        endfunction

        function void note_item(t_in_item it);
            int lim;
            int o;
            int n0;
            t_out_item r;
            n0 = rewritten_q.size();
            lim = int'(it.region_length);
            if (lim > DEF_MAX_REGION_BYTES) lim = DEF_MAX_REGION_BYTES;
            if (it.has_byte) begin
                o = int'(offset);
                if (o < lim) begin
                    case (phase)
                        PH_TAG: begin
                            // a tag needs room for its length byte too
                            if (o + 2 <= lim) begin
                                cur_tag = it.data_byte;
                                if (it.data_byte == ins_tag) seen = 1'b1;
                                if (!inserted && !seen && it.data_byte > ins_tag) begin
                                    emit_element();
                                    inserted = 1'b1;
                                end
                                emit(it.data_byte, 1'b1);
                                phase = PH_LEN;
                            end
                        end
                        PH_LEN: begin
                            emit(it.data_byte, 1'b1);
                            if (o + 1 + int'(it.data_byte) > lim) begin
                                phase = PH_DROP;
                            end else if (it.data_byte == 8'd0) begin
                                phase = PH_TAG;
                            end else begin
                                val_left = it.data_byte;
                                phase = PH_VAL;
                            end
                        end
                        PH_VAL: begin
                            emit(it.data_byte, 1'b1);
                            if (val_left > 0) val_left--;
                            if (val_left == 0) phase = PH_TAG;
                        end
                        default: ;
                    endcase
                end
                if (offset < DEF_MAX_REGION_BYTES) offset++;
            end
            if (it.region_end) begin
                if (!inserted && !seen) emit_element();
                if (rewritten_q.size() == n0) emit(8'd0, 1'b0);
                r = rewritten_q.pop_back();
                r.out_last = 1'b1;
                rewritten_q = {rewritten_q, r};
                clear_state();
                n_regions++;
            end
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", name, want, got);
                n_mismatch++;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (rewritten_q.size() == 0) begin
                $error("result item with none expected: out_byte %0h", got.out_byte);
                n_mismatch++;
                return;
            end
            want = rewritten_q.pop_front();
            n_checked++;
            cmp_field("out_byte", want.out_byte, got.out_byte);
            cmp_field("out_valid", 8'(want.out_valid), 8'(got.out_valid));
            cmp_field("out_last", 8'(want.out_last), 8'(got.out_last));
        endfunction
    endclass

    // block ports, inputs all known from time zero, reset held low at the start
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = CFG_INSERT_TAG;
    logic [31:0] i_cfg_wdata = '0;

    region_rewriter sb;
    int unsigned    cycle_cnt = 0;
    int unsigned    n_sent = 0;     // accepted input items
    int             burst_left = 0;
    bit             steady_tx = 1'b0;
    int             rx_mode = 0;
    int             rx_left = 0;

    tlv_element_inserter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver: stretches of always ready, coin flips, heavy stalling and light stalling
    always @(posedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(20, 200);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= ($urandom_range(0, 1) == 1);
            2: i_out_ready <= ((rx_left % 7) < 2);
            default: i_out_ready <= ($urandom_range(0, 9) != 0);
        endcase
    end

    // result items are checked as they leave, values as they stood at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_result(o_out_item);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic t_in_item mk(logic [7:0] b, logic has, logic [11:0] rlen, logic last);
        t_in_item it;
        it.data_byte = b;
        it.has_byte = has;
        it.region_length = rlen;
        it.region_end = last;
        return it;
    endfunction

    // tags clustered round the configured one so that equal and greater both turn up
    function automatic logic [7:0] pick_tag();
        logic [7:0] t;
        case ($urandom_range(0, 3))
            0: t = sb.ins_tag;
            1: t = sb.ins_tag + 8'($urandom_range(1, 3));
            2: t = sb.ins_tag - 8'($urandom_range(1, 3));
            default: t = 8'($urandom);
        endcase
        return t;
    endfunction

    // offer one item, hold it until taken, then maybe pause between bursts
    task automatic push_item(input t_in_item it);
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_item(it);
        n_sent++;
        if (!steady_tx) begin
            if (burst_left == 0) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge i_clk);
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // wait for the block to go quiet: input dropped, all results back, then a further idle wait
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.rewritten_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // three back-to-back register writes, enable dropped once at the end
    task automatic write_config(input logic [7:0] tag, input logic [2:0] len,
                                input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_INSERT_TAG;
        i_cfg_wdata <= {24'd0, tag};
        @(posedge i_clk);
        sb.set_reg(CFG_INSERT_TAG, {24'd0, tag});
        i_cfg_index <= CFG_INSERT_LENGTH;
        i_cfg_wdata <= {29'd0, len};
        @(posedge i_clk);
        sb.set_reg(CFG_INSERT_LENGTH, {29'd0, len});
        i_cfg_index <= CFG_INSERT_VALUE;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        sb.set_reg(CFG_INSERT_VALUE, val);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one region: mostly well-formed elements, otherwise bent lengths and stray bytes
    task automatic send_region(input bit clean);
        logic [7:0] tags[$];
        logic [7:0] bytes[$];
        int         n_el;
        int         len;
        int         rlen;
        int         alt_len;
        int         mode;
        bit         end_marker;
        n_el = $urandom_range(0, 3);
        for (int e = 0; e < n_el; e++) tags = {tags, pick_tag()};
        // ascending tags half the time, the usual order in a real frame
        if ($urandom_range(0, 1) == 1) tags.sort();
        foreach (tags[e]) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 16) : $urandom_range(0, 4);
            bytes = {bytes, tags[e]};
            bytes = {bytes, 8'(len)};
            for (int k = 0; k < len; k++) bytes = {bytes, 8'($urandom)};
        end
        rlen = bytes.size();
        mode = clean ? -1 : $urandom_range(0, 4);
        case (mode)
            0: rlen = $urandom_range(0, bytes.size());          // value overruns, bytes past end
            1: rlen = $urandom_range(bytes.size(), 4095);       // region claims more than it carries
            2: begin                                            // lone trailing tag
                bytes = {bytes, pick_tag()};
                rlen = bytes.size();
            end
            3: ;                                                // length changes half way
            4: begin                                            // plain noise
                bytes.delete();
                repeat ($urandom_range(1, 20)) bytes = {bytes, 8'($urandom)};
                rlen = $urandom_range(0, 4095);
            end
            default: ;
        endcase
        alt_len = (mode == 3) ? $urandom_range(0, 4095) : rlen;
        end_marker = (bytes.size() == 0) || ($urandom_range(0, 2) == 0);
        foreach (bytes[i]) begin
            // markers with no end flag should leave the parse untouched
            if ($urandom_range(0, 7) == 0)
                push_item(mk(8'($urandom), 1'b0, 12'($urandom), 1'b0));
            push_item(mk(bytes[i], 1'b1,
                         12'((i >= bytes.size() / 2) ? alt_len : rlen),
                         !end_marker && (i == bytes.size() - 1)));
        end
        if (end_marker) push_item(mk(8'($urandom), 1'b0, 12'(alt_len), 1'b1));
    endtask

    initial begin
        int unsigned phase_goal;
        sb = new();

        // hold reset, then let it go
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed part, reset configuration (tag 0x25, three value bytes)
        // empty region: element appended alone
        push_item(mk(8'h00, 1'b0, 12'd0, 1'b1));
        // bare marker without end does nothing
        push_item(mk(8'hA5, 1'b0, 12'd0, 1'b0));
        // greater tag: element goes in front of it
        push_item(mk(8'h30, 1'b1, 12'd3, 1'b0));
        push_item(mk(8'h01, 1'b1, 12'd3, 1'b0));
        push_item(mk(8'hAA, 1'b1, 12'd3, 1'b1));
        // same tag already present, zero length element: nothing added
        push_item(mk(8'h25, 1'b1, 12'd2, 1'b0));
        push_item(mk(8'h00, 1'b1, 12'd2, 1'b1));
        // lone trailing tag dropped, element appended
        push_item(mk(8'h05, 1'b1, 12'd1, 1'b1));
        // value overruns the region: tag and length kept, rest dropped
        push_item(mk(8'h01, 1'b1, 12'd4, 1'b0));
        push_item(mk(8'hFF, 1'b1, 12'd4, 1'b0));
        push_item(mk(8'h11, 1'b1, 12'd4, 1'b0));
        push_item(mk(8'h22, 1'b1, 12'd4, 1'b0));
        push_item(mk(8'h00, 1'b0, 12'd4, 1'b1));
        // byte beyond a zero length region
        push_item(mk(8'hFF, 1'b1, 12'd0, 1'b1));
        // region length changing between items, largest length included
        push_item(mk(8'h00, 1'b1, 12'd4095, 1'b0));
        push_item(mk(8'h02, 1'b1, 12'd4095, 1'b0));
        push_item(mk(8'hFF, 1'b1, 12'd2, 1'b0));
        push_item(mk(8'hFF, 1'b1, 12'd4095, 1'b1));
        // largest tag forces insertion at the start
        push_item(mk(8'hFF, 1'b1, 12'd3, 1'b0));
        push_item(mk(8'h01, 1'b1, 12'd3, 1'b0));
        push_item(mk(8'h00, 1'b1, 12'd3, 1'b0));
        push_item(mk(8'hFF, 1'b0, 12'd3, 1'b1));
        settle();

        // random regions under four settings, smallest and largest among them
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: write_config(8'h00, 3'd0, 32'h0000_0000);
                1: write_config(8'hFF, 3'd7, 32'hFFFF_FFFF);
                2: write_config(8'($urandom), 3'd4, $urandom);
                default: write_config(8'($urandom_range(8'h20, 8'h40)),
                                      3'($urandom_range(0, 7)), $urandom);
            endcase
            steady_tx = (p == 2);
            burst_left = 0;
            phase_goal = n_sent + 45;
            while (n_sent < phase_goal) send_region($urandom_range(0, 9) < 7);
            settle();
        end

        $display("ran %0d regions, %0d input items, %0d result items compared",
                 sb.n_regions, n_sent, sb.n_checked);
        $display("settings: reset, tag 0 with no value, tag 255 with clipped length, two random");
        if (sb.n_mismatch == 0 && sb.rewritten_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/tlv_pkg.sv
src/tlv_parse.sv
src/tlv_out_queue.sv
src/tlv_element_inserter.sv
src/tlv_checker.sv
sim/tb.sv
